>>> hdl/esi_pkg.sv
// Shared types, widths and codes for the edge shape interpolation block.
package esi_pkg;

	// Data formats.
	localparam int VALUE_WIDTH        = 32;
	localparam int POSITION_FRAC_BITS = 15;
	localparam int POS_W              = 16;
	localparam int MODE_W             = 2;

	// Lane arithmetic widths.
	localparam int NUM_LANES = 4;
	localparam int FAC_W     = 21;
	localparam int PRD_W     = 2 * FAC_W;
	localparam int RAW_W     = PRD_W + FAC_W;
	localparam int WGT_W     = 52;
	localparam int WLO_W     = 26;
	localparam int WHI_W     = WGT_W - WLO_W;
	localparam int PL_W      = WLO_W + 1 + VALUE_WIDTH;
	localparam int PH_W      = WHI_W + VALUE_WIDTH;
	localparam int LPR_W     = 84;
	localparam int ACC_W     = 86;

	// All weights are brought to the cubic scale, so one rounding shift serves every mode.
	localparam int RND_SHIFT = 3 * POSITION_FRAC_BITS + 1;
	localparam int RES_W     = ACC_W - RND_SHIFT;
	localparam int SH_W      = 5;
	localparam logic [SH_W-1:0] SH_LINEAR = SH_W'(RND_SHIFT - POSITION_FRAC_BITS);
	localparam logic [SH_W-1:0] SH_QUAD   = SH_W'(RND_SHIFT - 2 * POSITION_FRAC_BITS);
	localparam logic [SH_W-1:0] SH_CUBIC  = SH_W'(0);

	// Pipeline depth from the accepting edge to the result register.
	localparam int LATENCY = 8;

	// Element order codes.
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

	// Saturation limits.
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [MODE_W-1:0]             mode;
		logic [POS_W-1:0]              position;
		logic signed [VALUE_WIDTH-1:0] node_value_0;
		logic signed [VALUE_WIDTH-1:0] node_value_1;
		logic signed [VALUE_WIDTH-1:0] node_value_2;
		logic signed [VALUE_WIDTH-1:0] node_value_3;
	} esi_req_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] interpolated;
		logic                          saturated;
		logic                          bad_mode;
	} esi_rsp_t;

	// Three factors whose product is one lane's shape weight.
	typedef struct packed {
		logic signed [FAC_W-1:0] f1;
		logic signed [FAC_W-1:0] f2;
		logic signed [FAC_W-1:0] f3;
	} esi_fac_t;

endpackage

>>> hdl/edge_shape_interpolate.sv
// Top level of the 1D Lagrange edge shape interpolation block.
//
//  Channel  | Handshake      | Payload    | Direction
//  ---------+----------------+------------+----------
//  request  | start / busy   | req        | in
//  result   | done (strobe)  | rsp        | out
//
// A request is taken on any cycle with start high; busy stays low, so one request
// per cycle is sustained.
// Each result appears on rsp for one cycle with done high, once its request has passed
// through the fixed pipeline of factor, multiply and merge stages.
// Results come out in request order; the receiver cannot stall them.
// Reset clears only the valid bits of the pipeline; no results follow reset
// until new requests arrive.
module edge_shape_interpolate (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  esi_pkg::esi_req_t req,
	output logic              done,
	output esi_pkg::esi_rsp_t rsp
);
	import esi_pkg::*;

	esi_fac_t                      fac_s1 [NUM_LANES];
	logic [SH_W-1:0]               sh_s1;
	logic signed [VALUE_WIDTH-1:0] val_s1 [NUM_LANES];
	logic signed [LPR_W-1:0]       prod_s5 [NUM_LANES];
	logic signed [VALUE_WIDTH-1:0] interp_s8;
	logic                          sat_s8;
	logic [LATENCY-1:0]            vld_q;
	logic [LATENCY-1:0]            bad_q;

	// The pipeline takes a request every cycle.
	assign busy = 1'b0;

	// Valid bits follow each request down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	// The invalid-order flag travels alongside; the lanes already give zero for it.
	always_ff @(posedge clk) begin
		bad_q <= {bad_q[LATENCY-2:0], (req.mode == MODE_BAD)};
	end

	esi_factor u_factor (
		.clk    (clk),
		.req    (req),
		.fac_s1 (fac_s1),
		.sh_s1  (sh_s1),
		.val_s1 (val_s1)
	);

	// One lane per node slot.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		esi_lane u_lane (
			.clk     (clk),
			.fac_s1  (fac_s1[g]),
			.sh_s1   (sh_s1),
			.val_s1  (val_s1[g]),
			.prod_s5 (prod_s5[g])
		);
	end

	esi_merge u_merge (
		.clk       (clk),
		.prod_s5   (prod_s5),
		.interp_s8 (interp_s8),
		.sat_s8    (sat_s8)
	);

	// Result port.
	assign done             = vld_q[LATENCY-1];
	assign rsp.interpolated = interp_s8;
	assign rsp.saturated    = sat_s8;
	assign rsp.bad_mode     = bad_q[LATENCY-1];

	// Every result belongs to a request taken a fixed number of cycles earlier.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching request");

	// The error flag matches the order code of that request.
	a_bad_tracks_mode: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.bad_mode == ($past(req.mode, LATENCY) == MODE_BAD)))
		else $error("bad_mode does not match request order");

	// An invalid order gives a zero, unsaturated result.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_mode) |-> (rsp.interpolated == '0 && !rsp.saturated))
		else $error("invalid order produced a nonzero result");

	// A saturated result sits at one of the limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.saturated) |-> (rsp.interpolated == VAL_MAX || rsp.interpolated == VAL_MIN))
		else $error("saturated result not at a limit");

endmodule

>>> hdl/esi_factor.sv
// Front stage: clamps the position and forms the shape factors of every lane.
module esi_factor (
	input  logic                                   clk,
	input  esi_pkg::esi_req_t                      req,
	output esi_pkg::esi_fac_t                      fac_s1 [esi_pkg::NUM_LANES],
	output logic [esi_pkg::SH_W-1:0]               sh_s1,
	output logic signed [esi_pkg::VALUE_WIDTH-1:0] val_s1 [esi_pkg::NUM_LANES]
);
	import esi_pkg::*;

	localparam logic [POS_W-1:0]        P_ONE  = POS_W'(1 << POSITION_FRAC_BITS);
	localparam logic signed [FAC_W-1:0] F_ONE  = FAC_W'(1 << POSITION_FRAC_BITS);
	localparam logic signed [FAC_W-1:0] F_UNIT = FAC_W'(1);

	logic [POS_W-1:0]        p;
	logic signed [FAC_W-1:0] ps, sm, p2, p3;
	esi_fac_t                fac [NUM_LANES];
	logic [SH_W-1:0]         sh;

	// Positions above one are taken as exactly one.
	assign p  = (req.position > P_ONE) ? P_ONE : req.position;
	assign ps = signed'(FAC_W'(p));
	assign sm = F_ONE - ps;
	assign p2 = ps + ps;
	assign p3 = p2 + ps;

	// Shape factors per lane for the selected element order.
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			fac[i] = '0;
		end
		sh = SH_CUBIC;
		case (req.mode)
			MODE_LINEAR: begin
				fac[0] = '{f1: sm, f2: F_UNIT, f3: F_UNIT};
				fac[1] = '{f1: ps, f2: F_UNIT, f3: F_UNIT};
				sh     = SH_LINEAR;
			end
			MODE_QUAD: begin
				fac[0] = '{f1: sm, f2: F_ONE - p2, f3: F_UNIT};
				fac[1] = '{f1: ps, f2: p2 - F_ONE, f3: F_UNIT};
				fac[2] = '{f1: sm <<< 2, f2: ps, f3: F_UNIT};
				sh     = SH_QUAD;
			end
			MODE_CUBIC: begin
				fac[0] = '{f1: sm, f2: p3 - F_ONE, f3: p3 - (F_ONE <<< 1)};
				fac[1] = '{f1: ps, f2: p3 - F_ONE, f3: p3 - (F_ONE <<< 1)};
				fac[2] = '{f1: (ps <<< 3) + ps, f2: ps - F_ONE, f3: p3 - (F_ONE <<< 1)};
				fac[3] = '{f1: (ps <<< 3) + ps, f2: sm, f3: p3 - F_ONE};
				sh     = SH_CUBIC;
			end
			default: begin
				sh = SH_CUBIC;
			end
		endcase
	end

	// Stage 1 registers.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_LANES; i++) begin
			fac_s1[i] <= fac[i];
		end
		sh_s1     <= sh;
		val_s1[0] <= req.node_value_0;
		val_s1[1] <= req.node_value_1;
		val_s1[2] <= req.node_value_2;
		val_s1[3] <= req.node_value_3;
	end

endmodule

>>> hdl/esi_lane.sv
// One lane: builds a shape weight and multiplies it by its nodal value.
module esi_lane (
	input  logic                                   clk,
	input  esi_pkg::esi_fac_t                      fac_s1,
	input  logic [esi_pkg::SH_W-1:0]               sh_s1,
	input  logic signed [esi_pkg::VALUE_WIDTH-1:0] val_s1,
	output logic signed [esi_pkg::LPR_W-1:0]       prod_s5
);
	import esi_pkg::*;

	logic signed [PRD_W-1:0]       p12_s2;
	logic signed [FAC_W-1:0]       f3_s2;
	logic [SH_W-1:0]               sh_s2;
	logic signed [VALUE_WIDTH-1:0] val_s2, val_s3;
	logic signed [RAW_W-1:0]       raw;
	logic signed [RAW_W-1:0]       raw_sh;
	logic signed [WGT_W-1:0]       wgt_s3;
	logic signed [WLO_W:0]         wlo;
	logic signed [WHI_W-1:0]       whi;
	logic signed [PL_W-1:0]        pl_s4;
	logic signed [PH_W-1:0]        ph_s4;

	// Stage 2: product of the first two factors.
	always_ff @(posedge clk) begin
		p12_s2 <= fac_s1.f1 * fac_s1.f2;
		f3_s2  <= fac_s1.f3;
		sh_s2  <= sh_s1;
		val_s2 <= val_s1;
	end

	// Stage 3: third factor, then scaling to the common fraction width.
	assign raw    = p12_s2 * f3_s2;
	assign raw_sh = raw <<< sh_s2;

	always_ff @(posedge clk) begin
		wgt_s3 <= signed'(raw_sh[WGT_W-1:0]);
		val_s3 <= val_s2;
	end

	// Stage 4: weight times value as two partial products.
	assign wlo = signed'({1'b0, wgt_s3[WLO_W-1:0]});
	assign whi = signed'(wgt_s3[WGT_W-1:WLO_W]);

	always_ff @(posedge clk) begin
		pl_s4 <= wlo * val_s3;
		ph_s4 <= whi * val_s3;
	end

	// Stage 5: recombine the partial products.
	always_ff @(posedge clk) begin
		prod_s5 <= (LPR_W'(ph_s4) <<< WLO_W) + LPR_W'(pl_s4);
	end

endmodule

>>> hdl/esi_merge.sv
// Merge stages: sums the lane products, rounds once and saturates.
module esi_merge (
	input  logic                                   clk,
	input  logic signed [esi_pkg::LPR_W-1:0]       prod_s5 [esi_pkg::NUM_LANES],
	output logic signed [esi_pkg::VALUE_WIDTH-1:0] interp_s8,
	output logic                                   sat_s8
);
	import esi_pkg::*;

	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(1) <<< (RND_SHIFT - 1);

	logic signed [ACC_W-1:0] sum01_s6, sum23_s6, tot_s7;
	logic signed [RES_W-1:0] res;
	logic                    ovf;

	// Stage 6: pairwise sums.
	always_ff @(posedge clk) begin
		sum01_s6 <= ACC_W'(prod_s5[0]) + ACC_W'(prod_s5[1]);
		sum23_s6 <= ACC_W'(prod_s5[2]) + ACC_W'(prod_s5[3]);
	end

	// Stage 7: full sum with the half-unit bias, so the shift rounds ties upward.
	always_ff @(posedge clk) begin
		tot_s7 <= sum01_s6 + sum23_s6 + BIAS;
	end

	// Drop the fraction and check that the result fits the output width.
	assign res = signed'(tot_s7[ACC_W-1:RND_SHIFT]);
	assign ovf = (res[RES_W-1:VALUE_WIDTH-1] != {(RES_W-VALUE_WIDTH+1){res[VALUE_WIDTH-1]}});

	// Stage 8: clamp and register the result.
	always_ff @(posedge clk) begin
		if (ovf) begin
			interp_s8 <= res[RES_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			interp_s8 <= signed'(res[VALUE_WIDTH-1:0]);
		end
		sat_s8 <= ovf;
	end

endmodule
